/* src/assert_macros.svh */
// Assertion macros shared by the one-wire master RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLY(name, pre, post, msg)
`define ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

/* src/owts_pkg.sv */
// Package with types, constants and the command sequence table of the one-wire master.
package owts_pkg;

	localparam int TICK_WIDTH   = 16;
	localparam int ROM_ID_BYTES = 4;
	localparam int CFG_W        = 16;
	localparam int CFG_NUM      = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int STEP_W       = 4;
	localparam int BYTE_IDX_W   = 4;

	localparam logic [47:0] TICK_CAP = (48'd1 << TICK_WIDTH) - 48'd1;

	localparam logic [2:0] REQ_NONE       = 3'd0;
	localparam logic [2:0] REQ_RESET      = 3'd1;
	localparam logic [2:0] REQ_WRITE      = 3'd2;
	localparam logic [2:0] REQ_READ       = 3'd3;
	localparam logic [2:0] REQ_CONVERT    = 3'd4;
	localparam logic [2:0] REQ_READ_TEMP  = 3'd5;
	localparam logic [2:0] REQ_READ_ROM   = 3'd6;

	localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
	localparam logic [7:0] CMD_CONVERT   = 8'h44;
	localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
	localparam logic [7:0] CMD_READ_ROM  = 8'h33;

	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LOW      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_HOLD     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 3'd7;

	localparam logic [CFG_W-1:0] CFG_DEFAULTS [CFG_NUM] = '{
		16'd3500, 16'd400, 16'd2000, 16'd1800, 16'd1, 16'd2, 16'd1200, 16'd1
	};

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_TAIL,
		PH_GAP,
		PH_SLOT_LOW,
		PH_W_DATA,
		PH_R_WAIT,
		PH_R_HOLD,
		PH_RECOV
	} phase_t;

	typedef enum logic [2:0] {
		OP_END,
		OP_RESET,
		OP_RESET_GAP,
		OP_WRITE,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} op_sel_t;

	typedef struct packed {
		logic        line;
		logic        busy;
		logic        done;
		logic        presence;
		logic [31:0] value;
	} res_t;

	function automatic op_sel_t op_at(input logic [2:0] cmd, input logic [STEP_W-1:0] step,
		input logic [7:0] first_byte);
		op_sel_t s;
		s.op   = OP_END;
		s.data = 8'h00;
		case (cmd)
			REQ_RESET: begin
				if (step == 0) s.op = OP_RESET;
			end
			REQ_WRITE: begin
				s.data = first_byte;
				if (step == 0) s.op = OP_WRITE;
			end
			REQ_READ: begin
				if (step == 0) s.op = OP_READ;
			end
			REQ_CONVERT: begin
				case (step)
					4'd0: s.op = OP_RESET_GAP;
					4'd1: begin s.op = OP_WRITE; s.data = CMD_SKIP_ROM; end
					4'd2: begin s.op = OP_WRITE; s.data = CMD_CONVERT; end
					default: s.op = OP_END;
				endcase
			end
			REQ_READ_TEMP: begin
				case (step)
					4'd0, 4'd3: s.op = OP_RESET_GAP;
					4'd1, 4'd4: begin s.op = OP_WRITE; s.data = CMD_SKIP_ROM; end
					4'd2: begin s.op = OP_WRITE; s.data = CMD_CONVERT; end
					4'd5: begin s.op = OP_WRITE; s.data = CMD_READ_PAD; end
					4'd6, 4'd7: s.op = OP_READ;
					default: s.op = OP_END;
				endcase
			end
			REQ_READ_ROM: begin
				if (step == 0) s.op = OP_RESET_GAP;
				else if (step == 1) begin
					s.op   = OP_WRITE;
					s.data = CMD_READ_ROM;
				end else if (int'(step) < 2 + ROM_ID_BYTES) s.op = OP_READ;
			end
			default: s.op = OP_END;
		endcase
		return s;
	endfunction

endpackage

/* src/owts_cfg_regs.sv */
// Timing register file and phase length selection of the one-wire master.
module owts_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [owts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [owts_pkg::CFG_W-1:0]     cfg_wdata,
	input  owts_pkg::phase_t               len_phase,
	output logic [owts_pkg::TICK_WIDTH-1:0] phase_len
);
	import owts_pkg::*;

	logic [CFG_W-1:0] regs_q [CFG_NUM];
	logic [CFG_W-1:0] raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) regs_q[i] <= CFG_DEFAULTS[i];
		end else if (cfg_we) begin
			regs_q[cfg_index] <= cfg_wdata;
		end
	end

	always_comb begin
		case (len_phase)
			PH_RST_LOW:          raw = regs_q[CFG_RESET_LOW];
			PH_RST_WAIT:         raw = regs_q[CFG_PRESENCE_WAIT];
			PH_RST_TAIL:         raw = regs_q[CFG_RESET_TAIL];
			PH_GAP:              raw = regs_q[CFG_GAP];
			PH_SLOT_LOW:         raw = regs_q[CFG_SLOT_LOW];
			PH_R_WAIT:           raw = regs_q[CFG_READ_SAMPLE];
			PH_W_DATA, PH_R_HOLD: raw = regs_q[CFG_SLOT_HOLD];
			default:             raw = regs_q[CFG_RECOVERY];
		endcase
		if (raw == '0) begin
			phase_len = TICK_WIDTH'(1);
		end else if (48'(raw) > TICK_CAP) begin
			phase_len = TICK_CAP[TICK_WIDTH-1:0];
		end else begin
			phase_len = TICK_WIDTH'(raw);
		end
	end

endmodule

/* src/owts_engine.sv */
// Bus phase sequencer that advances the one-wire master by one tick per transfer.
`include "assert_macros.svh"

module owts_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step_en,
	input  logic [2:0]                      req_type,
	input  logic [7:0]                      tx_byte,
	input  logic                            line_in,
	input  logic [owts_pkg::TICK_WIDTH-1:0] phase_len,
	output owts_pkg::phase_t                len_phase,
	output owts_pkg::res_t                  res
);
	import owts_pkg::*;

	phase_t                phase_q;
	logic [STEP_W-1:0]     step_q;
	logic [TICK_WIDTH-1:0] tick_q;
	logic [2:0]            bit_q;
	logic [BYTE_IDX_W-1:0] bidx_q;
	logic [7:0]            shift_q;
	logic [31:0]           acc_q;
	logic                  pres_q;
	logic [2:0]            cmd_q;
	op_t                   op_q;

	phase_t                l_phase;
	logic [STEP_W-1:0]     l_step;
	logic [TICK_WIDTH-1:0] l_tick;
	logic [2:0]            l_bit;
	logic [BYTE_IDX_W-1:0] l_bidx;
	logic [7:0]            l_shift;
	logic [31:0]           l_acc;
	logic [2:0]            l_cmd;
	op_t                   l_op;
	logic                  launch;

	phase_t                n_phase;
	logic [STEP_W-1:0]     n_step;
	logic [TICK_WIDTH-1:0] n_tick;
	logic [2:0]            n_bit;
	logic [BYTE_IDX_W-1:0] n_bidx;
	logic [7:0]            n_shift;
	logic [31:0]           n_acc;
	logic                  n_pres;
	logic [2:0]            n_cmd;
	op_t                   n_op;
	logic                  n_level;
	logic                  n_done;

	assign launch = (phase_q == PH_IDLE) && (req_type inside {[REQ_RESET:REQ_READ_ROM]});

	always_comb begin
		op_sel_t sel;
		l_phase = phase_q;
		l_step  = step_q;
		l_tick  = tick_q;
		l_bit   = bit_q;
		l_bidx  = bidx_q;
		l_shift = shift_q;
		l_acc   = acc_q;
		l_cmd   = cmd_q;
		l_op    = op_q;
		sel     = op_at(req_type, '0, tx_byte);
		if (launch) begin
			l_cmd   = req_type;
			l_step  = '0;
			l_bidx  = '0;
			l_acc   = '0;
			l_op    = sel.op;
			l_tick  = '0;
			l_bit   = '0;
			l_shift = (sel.op == OP_WRITE) ? sel.data : 8'h00;
			l_phase = (sel.op == OP_RESET || sel.op == OP_RESET_GAP) ? PH_RST_LOW : PH_SLOT_LOW;
		end
	end

	assign len_phase = l_phase;

	always_comb begin
		logic [TICK_WIDTH:0] cnt;
		logic                advance;
		op_sel_t             sel;
		n_phase = l_phase;
		n_step  = l_step;
		n_tick  = l_tick;
		n_bit   = l_bit;
		n_bidx  = l_bidx;
		n_shift = l_shift;
		n_acc   = l_acc;
		n_pres  = pres_q;
		n_cmd   = l_cmd;
		n_op    = l_op;
		n_level = 1'b1;
		n_done  = 1'b0;
		advance = 1'b0;
		cnt     = {1'b0, l_tick} + (TICK_WIDTH+1)'(1);
		sel     = op_at(l_cmd, l_step + STEP_W'(1), 8'h00);
		if (l_phase != PH_IDLE) begin
			case (l_phase)
				PH_RST_LOW, PH_SLOT_LOW: n_level = 1'b0;
				PH_W_DATA:               n_level = l_shift[0];
				default:                 n_level = 1'b1;
			endcase
			n_tick = cnt[TICK_WIDTH-1:0];
			if (cnt >= {1'b0, phase_len}) begin
				n_tick = '0;
				case (l_phase)
					PH_RST_LOW: n_phase = PH_RST_WAIT;
					PH_RST_WAIT: begin
						n_pres  = line_in;
						n_phase = PH_RST_TAIL;
					end
					PH_RST_TAIL: begin
						if (l_op == OP_RESET_GAP) n_phase = PH_GAP;
						else advance = 1'b1;
					end
					PH_GAP: advance = 1'b1;
					PH_SLOT_LOW: n_phase = (l_op == OP_WRITE) ? PH_W_DATA : PH_R_WAIT;
					PH_W_DATA: n_phase = PH_RECOV;
					PH_R_WAIT: begin
						n_shift = {line_in, l_shift[7:1]};
						n_phase = PH_R_HOLD;
					end
					PH_R_HOLD: n_phase = PH_RECOV;
					default: begin
						if (l_op == OP_WRITE) n_shift = {1'b0, l_shift[7:1]};
						if (l_bit != 3'd7) begin
							n_bit   = l_bit + 3'd1;
							n_phase = PH_SLOT_LOW;
						end else begin
							n_bit = '0;
							if (l_op == OP_READ) begin
								if (l_bidx < BYTE_IDX_W'(4)) begin
									n_acc = l_acc | (32'(l_shift) << {l_bidx[1:0], 3'b000});
								end
								if (l_bidx != '1) n_bidx = l_bidx + BYTE_IDX_W'(1);
							end
							advance = 1'b1;
						end
					end
				endcase
				if (advance) begin
					n_step = l_step + STEP_W'(1);
					if (sel.op == OP_END) begin
						n_phase = PH_IDLE;
						n_cmd   = REQ_NONE;
						n_done  = 1'b1;
					end else begin
						n_op    = sel.op;
						n_tick  = '0;
						n_bit   = '0;
						n_shift = (sel.op == OP_WRITE) ? sel.data : 8'h00;
						n_phase = (sel.op == OP_RESET || sel.op == OP_RESET_GAP) ?
							PH_RST_LOW : PH_SLOT_LOW;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			step_q  <= '0;
			tick_q  <= '0;
			bit_q   <= '0;
			bidx_q  <= '0;
			shift_q <= '0;
			acc_q   <= '0;
			pres_q  <= 1'b1;
			cmd_q   <= REQ_NONE;
			op_q    <= OP_END;
		end else if (step_en) begin
			phase_q <= n_phase;
			step_q  <= n_step;
			tick_q  <= n_tick;
			bit_q   <= n_bit;
			bidx_q  <= n_bidx;
			shift_q <= n_shift;
			acc_q   <= n_acc;
			pres_q  <= n_pres;
			cmd_q   <= n_cmd;
			op_q    <= n_op;
		end
	end

	assign res.line     = n_level;
	assign res.busy     = (n_phase != PH_IDLE);
	assign res.done     = n_done;
	assign res.presence = n_pres;
	assign res.value    = n_acc;

	`ASSERT_IMPLY(a_idle_counters_clear, phase_q == PH_IDLE, (tick_q == '0) && (bit_q == '0), "idle phase with nonzero counters")
	`ASSERT_NEXT(a_launch_goes_busy, step_en && launch, phase_q != PH_IDLE, "accepted command did not start")

endmodule

/* src/onewire_temp_sensor_master.sv */
// Top level of the one-wire bus master with its tick channel and result register.
//
// Every input transfer is one bus tick: req_type, tx_byte and the sampled line_in.
// Every input transfer yields exactly one result transfer with line_out, busy_res,
// done_res, presence_level and read_value for that tick, in order.
// A command starts on a tick taken while no command is running; while busy,
// further commands are ignored but the tick still advances the bus timing.
// A tick's result is registered into the result register at the edge that accepts it.
// Throughput is one tick per cycle while out_ready is high, bounded by the single
// next-state pass of the phase sequencer between state registers and result register.
// in_ready is high when the result register is empty or is being taken, so a
// stalled receiver holds back input only while a result is waiting.
// The timing registers are written through cfg_we, cfg_index and cfg_wdata and
// should only change while no command runs.
// Reset returns the sequencer to idle with presence flag 1 and read value 0, the
// timing registers at their defaults and the result register empty (res_q not reset).
`include "assert_macros.svh"

module onewire_temp_sensor_master (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     req_type,
	input  logic [7:0]                     tx_byte,
	input  logic                           line_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           line_out,
	output logic                           busy_res,
	output logic                           done_res,
	output logic                           presence_level,
	output logic [31:0]                    read_value,
	input  logic                           cfg_we,
	input  logic [owts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [owts_pkg::CFG_W-1:0]     cfg_wdata
);
	import owts_pkg::*;

	logic                  step_en;
	logic                  out_valid_q;
	res_t                  res;
	res_t                  res_q;
	phase_t                len_phase;
	logic [TICK_WIDTH-1:0] phase_len;

	assign in_ready = !out_valid_q || out_ready;
	assign step_en  = in_valid && in_ready;

	owts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.len_phase (len_phase),
		.phase_len (phase_len)
	);

	owts_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.req_type  (req_type),
		.tx_byte   (tx_byte),
		.line_in   (line_in),
		.phase_len (phase_len),
		.len_phase (len_phase),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign line_out       = res_q.line;
	assign busy_res       = res_q.busy;
	assign done_res       = res_q.done;
	assign presence_level = res_q.presence;
	assign read_value     = res_q.value;

	`ASSERT_IMPLY(a_done_not_busy, out_valid_q && res_q.done, !res_q.busy, "done reported while still busy")
	`ASSERT_IMPLY(a_low_only_busy, out_valid_q && !res_q.line, res_q.busy, "bus driven low while idle")

endmodule
